>>> rtl/core/kcc_pkg.sv
// ----------------------------------------------------------------------------
// kcc_pkg
// shared constants, command codes and base decoding for the context counter
// ----------------------------------------------------------------------------
package kcc_pkg;

	// default sizing
	localparam int MAX_CONTEXT_DEF = 8;
	localparam int COUNT_BITS_DEF  = 32;

	// fixed field widths
	localparam int CMD_W       = 2;
	localparam int CHAR_W      = 8;
	localparam int QUERY_W     = 16;
	localparam int OUT_COUNT_W = 32;
	localparam int CFG_W       = 4;
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 48;

	localparam logic [CFG_W-1:0]       CFG_RESET     = 4'd3;
	localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = 32'hFFFF_FFFF;

	// result buffer depth
	localparam int OUT_DEPTH = 4;

	// ascii letters
	localparam logic [CHAR_W-1:0] CHAR_A      = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_C      = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_G      = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_T      = 8'h54;
	localparam logic [CHAR_W-1:0] CHAR_LOW_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOW_Z  = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

	// base codes
	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_C = 2'd1;
	localparam logic [1:0] CODE_G = 2'd2;
	localparam logic [1:0] CODE_T = 2'd3;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 2'd0,
		CMD_READ   = 2'd1,
		CMD_REGION = 2'd2
	} cmd_t;

	typedef enum logic {
		OP_INC   = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} base_t;

	// case-insensitive nucleotide decode
	function automatic base_t base_decode(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] up;
		base_t             r;
		up = ((ch >= CHAR_LOW_A) && (ch <= CHAR_LOW_Z)) ? (ch - CASE_OFFSET) : ch;
		r.ok   = 1'b1;
		r.code = CODE_A;
		case (up)
			CHAR_A: r.code = CODE_A;
			CHAR_C: r.code = CODE_C;
			CHAR_G: r.code = CODE_G;
			CHAR_T: r.code = CODE_T;
			default: r.ok = 1'b0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/kmer_context_counter.sv
// ----------------------------------------------------------------------------
// kmer_context_counter
// histogram of nucleotide contexts of length k in a direct-indexed count memory
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  tuser: cmd, tdata: base_char, query_code
// m_*       out        m_tvalid / m_tready  tdata: query_echo, count
// cfg_*     in         cfg_wen              cfg_wdata: context_len
//
// one transaction per cycle sustained while s_tready is high; the count memory
// read-modify-write is a registered read, then update and write back, with the
// last write forwarded so that back-to-back hits on one entry stay exact
// after reset a clearing pass writes zero to all 4^MAX_CONTEXT entries
// (65536 at the default size), while s_tready stays low
// a read result passes the stage 1 registers into the output buffer; outside
// the clearing pass, s_tready drops only when that buffer could overflow under
// a stalled m_tready
module kmer_context_counter
	import kcc_pkg::*;
#(
	parameter int MAX_CONTEXT = MAX_CONTEXT_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_wen,
	input  logic [CFG_W-1:0]      cfg_wdata,   // context_len
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,     // [7:0] base_char, [23:8] query_code
	input  logic [CMD_W-1:0]      s_tuser,     // [1:0] cmd
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata      // [15:0] query_echo, [47:16] count
);

	localparam int WIN_BITS = 2 * MAX_CONTEXT;
	localparam int ENTRIES  = 1 << WIN_BITS;
	localparam int RUN_W    = $clog2(MAX_CONTEXT + 1);
	localparam int QWIDE    = (WIN_BITS > QUERY_W) ? WIN_BITS : QUERY_W;
	localparam int CWIDE    = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
	localparam int PTR_W    = $clog2(OUT_DEPTH);
	localparam int OCC_W    = $clog2(OUT_DEPTH + 2);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [WIN_BITS-1:0]   ADDR_LAST = '1;

	// count in the upper bits, echo in the lowest bits of tdata
	typedef struct packed {
		logic [OUT_COUNT_W-1:0] count;
		logic [QUERY_W-1:0]     echo;
	} result_t;

	// configuration register
	logic [CFG_W-1:0] context_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			context_len_q <= CFG_RESET;
		end else if (cfg_wen) begin
			context_len_q <= cfg_wdata;
		end
	end

	// clearing pass after reset
	logic                clr_busy_q;
	logic [WIN_BITS-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// input unpacking
	cmd_t               in_cmd;
	logic [CHAR_W-1:0]  in_char;
	logic [QUERY_W-1:0] in_query;
	logic               in_fire;

	assign in_cmd   = cmd_t'(s_tuser);
	assign in_char  = s_tdata[CHAR_W-1:0];
	assign in_query = s_tdata[CHAR_W +: QUERY_W];
	assign in_fire  = s_tvalid && s_tready;

	// window and run state
	logic [WIN_BITS-1:0] window_q;
	logic [RUN_W-1:0]    run_q;

	// effective context length, clamped to 1..MAX_CONTEXT
	logic [CFG_W-1:0]    k_eff;
	logic [WIN_BITS-1:0] k_mask;
	base_t               base;
	logic [WIN_BITS-1:0] window_shift;
	logic [RUN_W-1:0]    run_inc;
	logic [QWIDE-1:0]    query_wide;

	// next state and memory request from the accepted transaction
	logic [WIN_BITS-1:0] window_d;
	logic [RUN_W-1:0]    run_d;
	logic                req_valid;
	op_t                 req_op;
	logic [WIN_BITS-1:0] req_idx;

	always_comb begin
		if (context_len_q == '0) begin
			k_eff = CFG_W'(1);
		end else if (context_len_q > CFG_W'(MAX_CONTEXT)) begin
			k_eff = CFG_W'(MAX_CONTEXT);
		end else begin
			k_eff = context_len_q;
		end
		for (int i = 0; i < WIN_BITS; i++) begin
			k_mask[i] = (i < 2 * int'(k_eff));
		end
	end

	always_comb begin
		base         = base_decode(in_char);
		window_shift = WIN_BITS'({window_q, base.code});
		run_inc      = (run_q < RUN_W'(MAX_CONTEXT)) ? (run_q + 1'b1) : run_q;
		query_wide   = QWIDE'(in_query);

		window_d  = window_q;
		run_d     = run_q;
		req_valid = 1'b0;
		req_op    = OP_INC;
		req_idx   = window_shift & k_mask;

		case (in_cmd)
			CMD_PUSH: begin
				if (base.ok) begin
					window_d  = window_shift;
					run_d     = run_inc;
					req_valid = (CFG_W'(run_inc) >= k_eff);
				end else begin
					// a non-acgt character breaks the run, window bits kept
					run_d = '0;
				end
			end
			CMD_READ: begin
				req_valid = 1'b1;
				req_op    = OP_CLEAR;
				req_idx   = query_wide[WIN_BITS-1:0];
			end
			CMD_REGION: begin
				window_d = '0;
				run_d    = '0;
			end
			default: begin
				// unused command: no effect
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			run_q    <= '0;
		end else if (in_fire) begin
			window_q <= window_d;
			run_q    <= run_d;
		end
	end

	// count memory
	logic [COUNT_BITS-1:0] count_mem [ENTRIES];
	logic [COUNT_BITS-1:0] mem_rdata_s1;
	logic                  mem_we;
	logic [WIN_BITS-1:0]   mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;

	always_ff @(posedge clk) begin
		if (in_fire && req_valid) begin
			mem_rdata_s1 <= count_mem[req_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			count_mem[mem_waddr] <= mem_wdata;
		end
	end

	// stage 1: read data back, modify, write
	logic                s1_valid;
	op_t                 s1_op;
	logic [WIN_BITS-1:0] s1_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= in_fire && req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && req_valid) begin
			s1_op  <= req_op;
			s1_idx <= req_idx;
		end
	end

	// stage 2: last write, forwarded over the read-before-write slot
	logic                  wr_valid_s2;
	logic [WIN_BITS-1:0]   wr_idx_s2;
	logic [COUNT_BITS-1:0] wr_val_s2;

	logic [COUNT_BITS-1:0] s1_cur;
	logic [COUNT_BITS-1:0] s1_new;
	logic [CWIDE-1:0]      s1_cur_wide;
	result_t               s1_result;

	always_comb begin
		s1_cur = (wr_valid_s2 && (wr_idx_s2 == s1_idx)) ? wr_val_s2 : mem_rdata_s1;
		case (s1_op)
			OP_INC:   s1_new = (s1_cur == COUNT_MAX) ? s1_cur : (s1_cur + 1'b1);
			OP_CLEAR: s1_new = '0;
			default:  s1_new = s1_cur;
		endcase
		// count field saturates when the stored count is wider
		s1_cur_wide     = CWIDE'(s1_cur);
		s1_result.echo  = QUERY_W'(QWIDE'(s1_idx));
		s1_result.count = (s1_cur_wide > CWIDE'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
		                                                       : s1_cur_wide[OUT_COUNT_W-1:0];
	end

	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = s1_valid;
			mem_waddr = s1_idx;
			mem_wdata = s1_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_s2 <= 1'b0;
		end else begin
			wr_valid_s2 <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			wr_idx_s2 <= s1_idx;
			wr_val_s2 <= s1_new;
		end
	end

	// result buffer
	result_t          out_buf_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [OCC_W-1:0] occ_q;
	logic             s1_push;
	logic             out_pop;

	assign s1_push = s1_valid && (s1_op == OP_CLEAR);
	assign out_pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (s1_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			occ_q <= occ_q + OCC_W'(s1_push) - OCC_W'(out_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_push) begin
			out_buf_q[wr_ptr_q] <= s1_result;
		end
	end

	assign m_tvalid = (occ_q != '0);
	assign m_tdata  = out_buf_q[rd_ptr_q];

	// room for the read in flight plus this one
	assign s_tready = !clr_busy_q && ((occ_q + OCC_W'(s1_push)) < OCC_W'(OUT_DEPTH));

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for kmer_context_counter: a queue-fed driver and a
// monitor that predicts every count read from its own histogram of contexts
// ----------------------------------------------------------------------------
module testbench;
	import kcc_pkg::*;

	localparam int HIST_ENTRIES   = 1 << (2 * MAX_CONTEXT_DEF);
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 4 * HIST_ENTRIES;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int REPORT_MAX     = 10;

	// command code the block ignores
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [CHAR_W-1:0] LETTER [4] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [CHAR_W-1:0]  base_char;
		logic [QUERY_W-1:0] query_code;
	} kmer_item_t;

	typedef struct {
		logic [QUERY_W-1:0]     query_echo;
		logic [OUT_COUNT_W-1:0] count;
	} count_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	kmer_context_counter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// histogram mirror and window state
	bit   [OUT_COUNT_W-1:0]   hist_mem [HIST_ENTRIES];
	logic [2*MAX_CONTEXT_DEF-1:0] model_window = '0;
	int                       model_run = 0;
	logic [CFG_W-1:0]         model_len = CFG_RESET;

	kmer_item_t    pending_items [$];
	count_result_t count_expected [$];

	// stimulus side copy of the window, used to aim reads at live contexts
	logic [QUERY_W-1:0] gen_window = '0;
	int                 gen_k = 3;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// hold-off requests from the stimulus, taken up by the receiver
	int rx_hold_req = 0;
	int rx_hold_ack = 0;
	int rx_hold_left = 0;

	int mismatch_count = 0;
	int items_taken = 0;
	int results_seen = 0;
	int stall_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int effective_len(input logic [CFG_W-1:0] len);
		if (len == 0)
			return 1;
		if (len > MAX_CONTEXT_DEF)
			return MAX_CONTEXT_DEF;
		return len;
	endfunction

	function automatic logic [QUERY_W-1:0] len_mask(input int k);
		return QUERY_W'((32'd1 << (2 * k)) - 1);
	endfunction

	// {ok, code}; lower case folded to upper case first
	function automatic logic [2:0] nucleotide_code(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] up;
		up = (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) ? ch - CASE_OFFSET : ch;
		case (up)
			CHAR_A:  return {1'b1, CODE_A};
			CHAR_C:  return {1'b1, CODE_C};
			CHAR_G:  return {1'b1, CODE_G};
			CHAR_T:  return {1'b1, CODE_T};
			default: return 3'b000;
		endcase
	endfunction

	// advance the histogram by one transaction, queue the count a read returns
	task automatic tally_context(input kmer_item_t it);
		logic [2:0]         dec;
		logic [QUERY_W-1:0] idx;
		count_result_t      res;
		int                 k;
		k = effective_len(model_len);
		case (it.cmd)
			CMD_PUSH: begin
				dec = nucleotide_code(it.base_char);
				if (!dec[2]) begin
					// window bits stay, only the run restarts
					model_run = 0;
				end else begin
					model_window = {model_window[2*MAX_CONTEXT_DEF-3:0], dec[1:0]};
					if (model_run < MAX_CONTEXT_DEF)
						model_run++;
					if (model_run >= k) begin
						idx = model_window & len_mask(k);
						if (hist_mem[idx] != '1)
							hist_mem[idx] = hist_mem[idx] + 1;
					end
				end
			end
			CMD_READ: begin
				idx = it.query_code & len_mask(MAX_CONTEXT_DEF);
				res.query_echo = idx;
				res.count = hist_mem[idx];
				hist_mem[idx] = '0;
				count_expected.push_back(res);
			end
			CMD_REGION: begin
				model_window = '0;
				model_run = 0;
			end
			default: ;
		endcase
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("mismatch %s: expected %0h, got %0h", what, want, got);
	endtask

	task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
		input logic [QUERY_W-1:0] q);
		kmer_item_t it;
		it.cmd = cmd;
		it.base_char = ch;
		it.query_code = q;
		pending_items.push_back(it);
	endtask

	// read aimed at the current window half the time, else at a random context of the current length or anywhere
	function automatic logic [QUERY_W-1:0] pick_query();
		int sel;
		sel = $urandom_range(3);
		if (sel < 2)
			return gen_window & len_mask(gen_k);
		if (sel == 2)
			return QUERY_W'($urandom_range(16'hFFFF)) & len_mask(gen_k);
		return QUERY_W'($urandom_range(16'hFFFF));
	endfunction

	// mostly ACGT runs in mixed case, with reads, noise, region breaks and unused commands
	task automatic add_random_item();
		kmer_item_t it;
		int         sel;
		logic [1:0] code;
		sel = $urandom_range(99);
		it.base_char = CHAR_W'($urandom_range(255));
		it.query_code = QUERY_W'($urandom_range(16'hFFFF));
		if (sel < 70) begin
			it.cmd = CMD_PUSH;
			if ($urandom_range(9) != 0) begin
				code = 2'($urandom_range(3));
				it.base_char = LETTER[code] + ($urandom_range(1) ? CASE_OFFSET : 8'h00);
				gen_window = {gen_window[QUERY_W-3:0], code};
			end
		end else if (sel < 90) begin
			it.cmd = CMD_READ;
			it.query_code = pick_query();
		end else if (sel < 95) begin
			it.cmd = CMD_REGION;
			gen_window = '0;
		end else begin
			it.cmd = CMD_UNUSED;
		end
		pending_items.push_back(it);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || s_tvalid || count_expected.size() != 0)
			@(negedge clk);
		// pushes leave no result, let the count pipeline settle
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_context_len(input logic [CFG_W-1:0] len);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_wen <= 1'b0;
		model_len = len;
		gen_k = effective_len(len);
		@(negedge clk);
	endtask

	// input driver: next transaction once the current one is taken
	always @(posedge clk or negedge arst_n) begin : driver_proc
		kmer_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				it = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {it.query_code, it.base_char};
				s_tuser <= it.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side backpressure, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin : receiver_proc
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_hold_ack != rx_hold_req) begin
			rx_hold_ack <= rx_hold_req;
			rx_hold_left <= RX_HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: check results, predict from accepted inputs, watch for hangs
	always @(posedge clk) begin : monitor_proc
		count_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (count_expected.size() == 0) begin
					note_mismatch("unexpected result, echo", '0, m_tdata[15:0]);
				end else begin
					want = count_expected.pop_front();
					if (m_tdata[15:0] !== want.query_echo)
						note_mismatch("query_echo", want.query_echo, m_tdata[15:0]);
					if (m_tdata[47:16] !== want.count)
						note_mismatch("count", want.count, m_tdata[47:16]);
				end
			end
			if (s_tvalid && s_tready) begin
				items_taken++;
				tally_context('{s_tuser, s_tdata[7:0], s_tdata[23:8]});
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin : stimulus_proc
		logic [CFG_W-1:0] len_plan [8];
		int               p;
		len_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd3, 4'd7};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at the reset length of three
		add_item(CMD_REGION, 8'h00, 16'h0000);
		add_item(CMD_PUSH, CHAR_A, 16'h0000);
		add_item(CMD_PUSH, CHAR_C + CASE_OFFSET, 16'hFFFF);
		add_item(CMD_PUSH, CHAR_G, 16'h0000);
		add_item(CMD_PUSH, CHAR_T + CASE_OFFSET, 16'h0000);
		add_item(CMD_PUSH, CHAR_T, 16'h0000);
		add_item(CMD_PUSH, CHAR_T + CASE_OFFSET, 16'h0000);
		add_item(CMD_PUSH, CHAR_T, 16'h0000);
		add_item(CMD_READ, 8'h00, 16'h003F);
		add_item(CMD_READ, 8'h00, 16'h001B);
		// characters that break the run, including neighbors of the letter range
		add_item(CMD_PUSH, 8'h4E, 16'h0000);
		add_item(CMD_PUSH, 8'h00, 16'h0000);
		add_item(CMD_PUSH, 8'hFF, 16'hFFFF);
		add_item(CMD_PUSH, 8'h60, 16'h0000);
		add_item(CMD_PUSH, 8'h7B, 16'h0000);
		add_item(CMD_PUSH, CHAR_LOW_Z, 16'h0000);
		add_item(CMD_PUSH, CHAR_A + CASE_OFFSET, 16'h0000);
		add_item(CMD_PUSH, CHAR_C, 16'h0000);
		add_item(CMD_PUSH, CHAR_G + CASE_OFFSET, 16'h0000);
		add_item(CMD_READ, 8'hFF, 16'h0006);
		add_item(CMD_READ, 8'hFF, 16'hFFFF);
		add_item(CMD_READ, 8'h00, 16'h0000);
		add_item(CMD_UNUSED, 8'hFF, 16'hFFFF);
		add_item(CMD_REGION, 8'hFF, 16'hFFFF);
		add_item(CMD_READ, 8'h00, 16'h003F);
		wait_drained();

		// random phases; window carries over each length change
		for (p = 0; p < 8; p++) begin
			write_context_len(len_plan[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			if (p == 4) begin
				// read burst against a stalled receiver fills the result buffer
				rx_hold_req++;
				repeat (40) add_item(CMD_READ, CHAR_W'($urandom_range(255)), pick_query());
			end
			repeat (80) add_random_item();
			// sender pauses here until every count has come back
			wait_drained();
			repeat (80) add_random_item();
			wait_drained();
		end

		$display("run: %0d input transactions, %0d count results checked", items_taken,
			results_seen);
		$display("run: context lengths 3 1 8 0 15 5 2 3 7, four traffic modes, one long hold");
		if (mismatch_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
